>>> hw/rtl/bcf_pkg.sv
// Shared types, constants and arithmetic helpers for the biquad cascade filter.
`default_nettype none

package bcf_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int STAGES       = 4;
  localparam int WORDS_PER_CH = 8;
  localparam int COEF_W       = 32;
  localparam int COEF_FRAC    = 29;
  localparam int SIG_W        = 33;
  localparam int ST_W         = 40;
  localparam int PROD_W       = COEF_W + SIG_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int SIG_POINT    = 28;
  localparam int MIX_FRAC     = 15;
  localparam int MIX_W        = 16;

  localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;

  typedef enum logic [2:0] {
    C_B0 = 3'd0,
    C_B1 = 3'd1,
    C_B2 = 3'd2,
    C_A1 = 3'd3,
    C_A2 = 3'd4
  } coef_sel_t;

  // Memory strobes from the sequencer
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  // b0, b1, b2, a1, a2 in Q3.29 per stage
  localparam logic signed [COEF_W-1:0] COEF_TAB [STAGES][5] = '{
    '{ 32'sd534391640, -32'sd1068783280, 32'sd534391640,
      -32'sd1068771834, 32'sd531923813 },
    '{ 32'sd537661981, -32'sd1072093367, 32'sd534490172,
      -32'sd1072093367, 32'sd535281242 },
    '{ 32'sd538217705, -32'sd1066846805, 32'sd528994807,
      -32'sd1066846805, 32'sd530341599 },
    '{ 32'sd32478506, 32'sd64957012, 32'sd32478506,
      -32'sd640950049, 32'sd233993164 }
  };

  localparam logic signed [ACC_W-1:0] COEF_HALF =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SIG_MAX =
    {{(ACC_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SIG_MIN = ~SIG_MAX;
  localparam logic signed [ACC_W-1:0] ST_MAX =
    {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;

  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] stage,
                                                    input coef_sel_t sel);
    return COEF_TAB[stage][sel];
  endfunction

  // Drop the coefficient fraction, rounding half up
  function automatic logic signed [ACC_W-1:0] rnd_coef(input logic signed [ACC_W-1:0] v);
    return (v + COEF_HALF) >>> COEF_FRAC;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v > SIG_MAX) ? SIG_MAX : ((v < SIG_MIN) ? SIG_MIN : v);
    return t[SIG_W-1:0];
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    return t[ST_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcf_stream_if.sv
// Valid/ready stream interfaces for the filter's sample input and output.
`default_nettype none

interface bcf_in_if import bcf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel_sel;

  modport source (output valid, output sample_in, output channel_sel, input ready);
  modport sink   (input valid, input sample_in, input channel_sel, output ready);
endinterface

interface bcf_out_if import bcf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bcf_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module bcf_mul import bcf_pkg::*; (
  input  logic                     clk,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [SIG_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

>>> hw/rtl/bcf_state_mem.sv
// Biquad delay-word memory, one word per access, with per-word valid bits.
`default_nettype none

module bcf_state_mem import bcf_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  mem_ctl_t                                  ctl,
  input  logic [$clog2(CHANNELS*WORDS_PER_CH)-1:0]  addr,
  input  logic signed [ST_W-1:0]                    wr_data,
  output logic signed [ST_W-1:0]                    rd_data
);

  localparam int DEPTH = CHANNELS * WORDS_PER_CH;

  logic signed [ST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_r;
  logic signed [ST_W-1:0] rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // never-written words read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> hw/rtl/biquad_cascade_cab_filter.sv
// Top level: four-stage biquad cascade with dry/wet mix on one shared multiplier.
//
//  port      | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  in_ch     | in  | valid/ready   | sample_in (SAMPLE_BITS, signed), channel_sel
//  out_ch    | out | valid/ready   | sample_out (SAMPLE_BITS, signed)
//  cfg_we    | in  | write strobe  | cfg_wdata: wet_mix, Q1.15, values > 1.0 clamp
//
// Steps: an input is taken only while idle. Each stage issues its five products
//   through the one multiplier, forms y and writes the new s0 and s1; the mix
//   issues the dry and wet shares, rounds and saturates, then hands the result
//   to the output register, and only then is the next input taken.
// Reset (rst_n, synchronous): sequencer idle, output empty, wet_mix 0, all
//   delay words read as zero through per-word valid bits. No clearing pass.
// Stalls: the output register holds a finished result while out_ch stalls;
//   the next input is taken meanwhile, and the block waits at handoff only
//   if the previous result still sits there.
`default_nettype none

module biquad_cascade_cab_filter import bcf_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bcf_in_if.sink           in_ch,
  bcf_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [MIX_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(CHANNELS * WORDS_PER_CH);
  // input alignment to Q6.27: left shift, or rounded right shift
  localparam int UP     = SIG_POINT - SAMPLE_BITS;
  localparam int UP_SH  = (UP > 0) ? UP : 0;
  localparam int DN_SH  = (UP < 0) ? -UP : 0;
  localparam int IN_W   = 34;
  localparam logic signed [IN_W-1:0] DN_HALF = (IN_W'(1) <<< DN_SH) >>> 1;
  // output: drop the mix fraction and the input alignment
  localparam int MIX_SH = MIX_FRAC + UP;
  localparam logic signed [ACC_W-1:0] MIX_HALF =
    {{(ACC_W-MIX_SH){1'b0}}, 1'b1, {(MIX_SH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,   // b0*x issued, s0 read
    ST_Y,    // y formed, b1*x issued, s1 read
    ST_A1,   // a1*y issued
    ST_N0,   // new s0 written, b2*x issued
    ST_B2,   // a2*y issued
    ST_N1,   // new s1 written, next stage
    ST_M0,   // dry share issued
    ST_M1,   // wet share issued
    ST_M2,   // round and saturate
    ST_OUT   // hand to output register
  } state_t;

  state_t                        state_r, state_nxt;
  logic [1:0]                    stage_r, stage_nxt;
  logic                          ch_r, ch_nxt;
  logic signed [SIG_W-1:0]       x_r, x_nxt;
  logic signed [SIG_W-1:0]       y_r, y_nxt;
  logic signed [SIG_W-1:0]       dry_r, dry_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic [MIX_W-1:0]              wet_mix_r;

  logic signed [COEF_W-1:0]      mul_a;
  logic signed [SIG_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       prod_x;
  logic signed [ST_W-1:0]        mem_rd;
  logic signed [ST_W-1:0]        mem_wr;
  mem_ctl_t                      mem_ctl;
  logic                          k_sel;
  logic [ADDR_W-1:0]             mem_addr;
  logic signed [IN_W-1:0]        in_ext;
  logic signed [SIG_W-1:0]       in_aligned;
  logic [MIX_W-1:0]              mix_m;
  logic [MIX_W-1:0]              mix_dry;
  logic signed [ACC_W-1:0]       mix_sum;
  logic signed [ACC_W-1:0]       mix_rnd;
  logic                          in_xfer;
  logic                          handoff;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  assign prod_x = ACC_W'(prod);

  assign mix_m   = (wet_mix_r > MIX_ONE) ? MIX_ONE : wet_mix_r;
  assign mix_dry = MIX_ONE - mix_m;

  always_comb begin
    in_ext = IN_W'(in_ch.sample_in);
    if (UP >= 0) begin
      in_aligned = SIG_W'(in_ext <<< UP_SH);
    end else begin
      in_aligned = SIG_W'((in_ext + DN_HALF) >>> DN_SH);
    end
  end

  bcf_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // word address: channel, stage, delay index
  assign k_sel    = (state_r == ST_Y) || (state_r == ST_N1);
  assign mem_addr = ADDR_W'({ch_r, stage_r, k_sel});

  bcf_state_mem #(
    .CHANNELS (CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  // multiplier operands per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_B0: begin
        mul_a = coef(stage_r, C_B0);
        mul_b = x_r;
      end
      ST_Y: begin
        mul_a = coef(stage_r, C_B1);
        mul_b = x_r;
      end
      ST_A1: begin
        mul_a = coef(stage_r, C_A1);
        mul_b = y_r;
      end
      ST_N0: begin
        mul_a = coef(stage_r, C_B2);
        mul_b = x_r;
      end
      ST_B2: begin
        mul_a = coef(stage_r, C_A2);
        mul_b = y_r;
      end
      ST_M0: begin
        mul_a = {{(COEF_W-MIX_W){1'b0}}, mix_dry};
        mul_b = dry_r;
      end
      ST_M1: begin
        mul_a = {{(COEF_W-MIX_W){1'b0}}, mix_m};
        mul_b = x_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mix_sum = acc_r + prod_x;
  assign mix_rnd = (mix_sum + MIX_HALF) >>> MIX_SH;
  assign handoff = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    ch_nxt        = ch_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dry_nxt       = dry_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mem_ctl       = '0;
    mem_wr        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // channel_sel is one bit, so only 0 and 1 can arrive; one channel forces 0
          ch_nxt    = (CHANNELS > 1) ? in_ch.channel_sel : 1'b0;
          dry_nxt   = in_aligned;
          x_nxt     = in_aligned;
          stage_nxt = '0;
          state_nxt = ST_B0;
        end
      end
      ST_B0: begin
        mem_ctl.rd = 1'b1;
        state_nxt  = ST_Y;
      end
      ST_Y: begin
        y_nxt      = sat_sig(rnd_coef(prod_x) + ACC_W'(mem_rd));
        mem_ctl.rd = 1'b1;
        state_nxt  = ST_A1;
      end
      ST_A1: begin
        acc_nxt   = prod_x;
        state_nxt = ST_N0;
      end
      ST_N0: begin
        // read data still holds the old s1
        mem_wr     = sat_st(rnd_coef(acc_r - prod_x) + ACC_W'(mem_rd));
        mem_ctl.wr = 1'b1;
        state_nxt  = ST_B2;
      end
      ST_B2: begin
        acc_nxt   = prod_x;
        state_nxt = ST_N1;
      end
      ST_N1: begin
        mem_wr     = sat_st(rnd_coef(acc_r - prod_x));
        mem_ctl.wr = 1'b1;
        x_nxt      = y_r;
        stage_nxt  = stage_r + 2'd1;
        state_nxt  = (stage_r == 2'(STAGES-1)) ? ST_M0 : ST_B0;
      end
      ST_M0: begin
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt   = prod_x;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        if (mix_rnd > OUT_MAX) begin
          res_nxt = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (mix_rnd < OUT_MIN) begin
          res_nxt = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
          res_nxt = mix_rnd[SAMPLE_BITS-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (handoff) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      wet_mix_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_we) begin
        wet_mix_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dry_r      <= dry_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bcf_checker.sv
// Port-level assertions for the biquad cascade filter, bound to the top level.
`default_nettype none

module bcf_checker import bcf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_data
);

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  // a new result only shows up after the block was busy
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work behind it");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind biquad_cascade_cab_filter bcf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);

`default_nettype wire

>>> verif/biquad_cascade_cab_filter_tb.sv
// Self-checking testbench for the biquad cascade cabinet filter with dry/wet mix.
`default_nettype none

module biquad_cascade_cab_filter_tb import bcf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // -------------------------------------------------------------------------
  // Run constants
  // -------------------------------------------------------------------------
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int SB           = SAMPLE_BITS_DEF;
  // Slowest correct run: the block's own work, sender gaps and receiver stalls
  // over ~1560 samples, plus one long output hold-off. Take it several times over.
  localparam int CYCLE_LIMIT  = 600000;
  // Watch window after the last expected result, for stray outputs.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_LEN = 400;

  // Mix settings (Q1.15)
  localparam logic [MIX_W-1:0] MIX_DRY      = 16'd0;
  localparam logic [MIX_W-1:0] MIX_WET      = 16'd32768;
  localparam logic [MIX_W-1:0] MIX_HALF     = 16'd16384;
  localparam logic [MIX_W-1:0] MIX_OVER_ONE = 16'd32769;
  localparam logic [MIX_W-1:0] MIX_ALL_ONES = 16'hFFFF;

  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  // -------------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // -------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [MIX_W-1:0] cfg_wdata;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bcf_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  bcf_out_if #(.SAMPLE_BITS(SB)) out_if ();

  biquad_cascade_cab_filter #(
    .CHANNELS    (CHANNELS_DEF),
    .SAMPLE_BITS (SB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // Shared testbench state
  // -------------------------------------------------------------------------
  logic [SB-1:0]        pending_samples[$];  // predicted outputs, oldest first
  int                   error_count = 0;
  int                   cycle_count = 0;
  bit                   src_idle_en = 1'b1;
  bit                   snk_idle_en = 1'b1;
  int                   hold_off_cycles = 0; // set by a test, counted down by the sink

  // Predictor copy of the block: mix register and per-channel delay words
  logic [MIX_W-1:0]     mix_setting;
  logic signed [39:0]   delay_word [CHANNELS_DEF][8];

  // Low-frequency square generator per channel, to pump the filter stages
  logic signed [SB-1:0] wave_level [CHANNELS_DEF];
  int                   wave_left  [CHANNELS_DEF];
  bit                   wave_pos   [CHANNELS_DEF];

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  // b0, b1, b2, a1, a2 in Q3.29, a0 normalized to one
  function automatic logic [0:4][31:0] stage_coefs(input int stage);
    case (stage)
      0: return {32'sd534391640, -32'sd1068783280, 32'sd534391640,
                 -32'sd1068771834, 32'sd531923813};
      1: return {32'sd537661981, -32'sd1072093367, 32'sd534490172,
                 -32'sd1072093367, 32'sd535281242};
      2: return {32'sd538217705, -32'sd1066846805, 32'sd528994807,
                 -32'sd1066846805, 32'sd530341599};
      default: return {32'sd32478506, 32'sd64957012, 32'sd32478506,
                       -32'sd640950049, 32'sd233993164};
    endcase
  endfunction

  // Arithmetic shift right with round half up
  function automatic logic signed [79:0] round_shift(input logic signed [79:0] v,
                                                     input int sh);
    return (v + (80'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [79:0] clip(input logic signed [79:0] v, input int bits);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = (80'sd1 <<< (bits - 1)) - 80'sd1;
    lo = -hi - 80'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One sample through the four TDF-II stages and the mix; updates delay words
  function automatic logic [SB-1:0] cab_filter_sample(input logic signed [SB-1:0] s,
                                                      input logic ch);
    logic [0:4][31:0]   c;
    logic signed [79:0] b0, b1, b2, a1, a2;
    logic signed [79:0] dry, x, y, m, acc;
    int                 st;
    dry = 80'(s);
    dry = dry * 16;                    // Q1.23 -> Q6.27
    x = dry;
    for (st = 0; st < 4; st++) begin
      c  = stage_coefs(st);
      b0 = 80'($signed(c[0]));
      b1 = 80'($signed(c[1]));
      b2 = 80'($signed(c[2]));
      a1 = 80'($signed(c[3]));
      a2 = 80'($signed(c[4]));
      y = clip(round_shift(b0 * x, 29) + delay_word[ch][2*st], 33);
      delay_word[ch][2*st]   = 40'(clip(round_shift(b1 * x - a1 * y, 29)
                                        + delay_word[ch][2*st+1], 40));
      delay_word[ch][2*st+1] = 40'(clip(round_shift(b2 * x - a2 * y, 29), 40));
      x = y;
    end
    m = 80'(mix_setting);
    if (m > 80'sd32768) m = 80'sd32768;  // mix above one acts as one
    acc = dry * (80'sd32768 - m) + x * m;
    return SB'(clip(round_shift(acc, 19), SB));
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // Offer one sample; returns once the transfer has happened.
  // valid stays high afterwards so back-to-back items need no extra assignment.
  task automatic send_sample(input logic signed [SB-1:0] s, input logic ch);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample_in   <= s;
    in_if.channel_sel <= ch;
    do @(posedge clk); while (!in_if.ready);
    pending_samples.push_back(cab_filter_sample(s, ch));
  endtask

  // Write wet_mix only with the pipeline empty
  task automatic write_mix(input logic [MIX_W-1:0] value);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    mix_setting  = value;
  endtask

  function automatic logic signed [SB-1:0] pick_sample(input logic ch);
    int amp;
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: return SB'($urandom);
      3: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      4: begin
        v = $urandom_range(0, 511) - 256;
        return SB'(v);
      end
      default: begin
        // new half period: random length and level, sign flips
        if (wave_left[ch] == 0) begin
          wave_left[ch] = $urandom_range(8, 400);
          wave_pos[ch]  = !wave_pos[ch];
          amp = $urandom_range(0, 8388607);
          if ($urandom_range(0, 3) == 0) amp = 8388607;
          if (wave_pos[ch]) wave_level[ch] = SB'(amp);
          else if ($urandom_range(0, 3) == 0) wave_level[ch] = SAMPLE_MIN;
          else wave_level[ch] = SB'(-amp);
        end
        wave_left[ch]--;
        return wave_level[ch];
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    logic ch;
    repeat (count) begin
      ch = 1'($urandom_range(0, 1));
      send_sample(pick_sample(ch), ch);
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Field extremes, impulses per channel, mix at dry, wet, over one, half
  task automatic test_directed();
    // reset mix is fully dry: output should track input
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    // fully wet: impulse responses, channels kept apart
    write_mix(MIX_WET);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample('0, 1'b1);
    send_sample('0, 1'b0);
    // all ones: clamps to fully wet; full-scale steps drive output saturation
    write_mix(MIX_ALL_ONES);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    // just above one, also clamped
    write_mix(MIX_OVER_ONE);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b0);
    // even blend
    write_mix(MIX_HALF);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(24'sd12345, 1'b1);
  endtask

  // Random traffic across several mix settings with idling on both sides
  task automatic test_random_mixes();
    write_mix(MIX_WET);
    send_random(220);
    write_mix(MIX_DRY);
    send_random(220);
    write_mix(16'd8192);
    send_random(220);
    write_mix(MIX_W'($urandom_range(0, 65535)));
    send_random(220);
    write_mix(16'd24576);
    send_random(220);
    write_mix(MIX_ALL_ONES);
    send_random(220);
  endtask

  // Receiver stalls for a long stretch while samples keep coming, so the
  // output register fills and the block pushes back on its input
  task automatic test_output_hold_off();
    write_mix(MIX_WET);
    @(posedge clk);
    hold_off_cycles = HOLD_OFF_LEN;
    send_random(20);
  endtask

  // Final stretch with no idling at all
  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    write_mix(MIX_W'($urandom_range(0, 32768)));
    send_random(200);
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off on request
  // -------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 9);  // start a stall burst
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [SB-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        error_count++;
        $display("%0t: unexpected sample_out: expected none, actual %0d", $time,
                 $signed(out_if.sample_out));
      end else begin
        want = pending_samples.pop_front();
        if (out_if.sample_out !== want) begin
          error_count++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time,
                   $signed(want), $signed(out_if.sample_out));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    in_if.valid       = 1'b0;
    in_if.sample_in   = '0;
    in_if.channel_sel = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    // predictor mirrors reset: dry mix, all delay words zero
    mix_setting = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      wave_level[c] = '0;
      wave_left[c]  = 0;
      wave_pos[c]   = 1'b0;
      for (int w = 0; w < 8; w++) delay_word[c][w] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mixes();
    test_output_hold_off();
    test_back_to_back();

    // drop valid, drain, then watch a while for stray results
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
